/* rtl/ic2d_pkg.sv */
package ic2d_pkg;

  localparam int MAX_KERNEL_DEF = 5;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int COEFF_BITS_DEF = 16;
  localparam int FRAC_BITS      = 12;
  localparam int MAX_HEIGHT     = 4096;
  localparam int NUM_CH         = 3;
  localparam int CH_W           = 8;
  localparam int PIX_W          = NUM_CH * CH_W;

  typedef enum logic [1:0] {
    OP_COEFF = 2'd0,
    OP_PIXEL = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_KROWS  = 3'd0,
    CFG_KCOLS  = 3'd1,
    CFG_WIDTH  = 3'd2,
    CFG_HEIGHT = 3'd3,
    CFG_COLOUR = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic en;
    logic shift;
  } cell_ctrl_t;

endpackage

/* rtl/ic2d_linebuf.sv */
module ic2d_linebuf import ic2d_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int AW    = $clog2(MAX_WIDTH_DEF),
  parameter int DW    = PIX_W
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // forward a same-cycle write to the read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ic2d_cell.sv */
module ic2d_cell import ic2d_pkg::*; #(
  parameter int MK = MAX_KERNEL_DEF,
  parameter int CB = COEFF_BITS_DEF,
  parameter int PW = CB + CH_W + 1,
  parameter int SW = PW + $clog2(MK)
) (
  input  logic                       clk_i,
  input  cell_ctrl_t                 ctrl_i,
  input  logic [MK-1:0][PIX_W-1:0]   col_i,
  output logic [MK-1:0][PIX_W-1:0]   col_o,
  input  logic [MK-1:0]              mask_i,
  input  logic [MK-1:0][CB-1:0]      coef_i,
  output logic [NUM_CH-1:0][SW-1:0]  sum_o
);

  logic [MK-1:0][PIX_W-1:0]          col_q;
  logic signed [PW-1:0]              prod_d [MK][NUM_CH];
  logic signed [PW-1:0]              prod_q [MK][NUM_CH];
  logic [NUM_CH-1:0][SW-1:0]         sum_d, sum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en && ctrl_i.shift) begin
      col_q <= col_i;
    end
  end

  always_comb begin
    logic [CH_W-1:0] pix;
    for (int k = 0; k < MK; k++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        pix = mask_i[k] ? col_q[k][ch*CH_W +: CH_W] : '0;
        prod_d[k][ch] = $signed({1'b0, pix}) * $signed(coef_i[k]);
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc = '0;
      for (int k = 0; k < MK; k++) begin
        acc = acc + SW'(prod_q[k][ch]);
      end
      sum_d[ch] = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
    end
  end

  assign col_o = col_q;
  assign sum_o = sum_q;

endmodule

/* rtl/image_2d_convolution.sv */
// Streaming 2D convolution with zero padding, one raster-order pixel per cycle unless stalled.
// Input channel (in_valid_i/in_ready_o): opcode selects a coefficient load
// (coeff_index_i = row*MAX_KERNEL+col, Q4.12 value), a pixel, or a flush item
// that pushes the frame tail through as padding. Opcode 3 is dropped.
// Output channel (out_valid_o/out_ready_i): filtered pixels in raster order,
// frame_last_o marks the last pixel of a frame. An output appears once the
// stream is ((kr-1)/2)*W + (kc-1)/2 items past its position.
// Config channel (cfg_valid_i/cfg_ready_o, always ready): index 0 kernel rows,
// 1 kernel cols, 2 frame width, 3 frame height, 4 colour mode. Write only when
// the pipeline is drained.
// Throughput: one transaction per cycle while the receiver is not stalling. The
// result register loads after the line buffer read at the accepting edge, then
// window shift, products in the tap cells, column sums, final sum, saturation.
// Reset clears counters and coefficients and sets the default configuration; line
// buffer contents are not cleared and need no clearing pass. When the receiver
// stalls, the whole pipeline holds and in_ready_o drops until the result is taken.
module image_2d_convolution import ic2d_pkg::*; #(
  parameter int MAX_KERNEL = MAX_KERNEL_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int COEFF_BITS = COEFF_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  coeff_index_i,
  input  logic signed [15:0] coeff_value_i,
  input  logic [7:0]  chan_a_i,
  input  logic [7:0]  chan_b_i,
  input  logic [7:0]  chan_c_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  res_a_o,
  output logic [7:0]  res_b_o,
  output logic [7:0]  res_c_o,
  output logic        frame_last_o
);

  localparam int MK      = MAX_KERNEL;
  localparam int CB      = COEFF_BITS;
  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = 13;
  localparam int LB_ROWS = (MK > 1) ? MK - 1 : 1;
  localparam int LAT_W   = $clog2(((MK - 1) / 2) * MAX_WIDTH + MK + 1);
  localparam int TOT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
  localparam int CIW     = (MK > 1) ? $clog2(MK * MK) : 1;
  localparam int PW      = CB + CH_W + 1;
  localparam int SW      = PW + $clog2(MK);
  localparam int ACC_W   = SW + $clog2(MK);
  localparam int EXT_W   = (ACC_W > 22) ? ACC_W : 22;

  // configuration
  logic [2:0]    krows_q, kcols_q;
  logic [10:0]   width_q;
  logic [12:0]   height_q;
  logic          colour_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      krows_q  <= 3'd3;
      kcols_q  <= 3'd3;
      width_q  <= 11'd640;
      height_q <= 13'd480;
      colour_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KROWS:  krows_q  <= cfg_data_i[2:0];
        CFG_KCOLS:  kcols_q  <= cfg_data_i[2:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[10:0];
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_COLOUR: colour_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [3:0]      kr, kc, rdel, cdel;
  logic [WW-1:0]   wc;
  logic [HW-1:0]   hc;
  logic [LAT_W-1:0] lat;
  logic [TOT_W-1:0] total_m1;

  always_comb begin
    if (krows_q == '0) kr = 4'd1;
    else if (int'(krows_q) > MK) kr = 4'(MK);
    else kr = {1'b0, krows_q};
    if (kcols_q == '0) kc = 4'd1;
    else if (int'(kcols_q) > MK) kc = 4'(MK);
    else kc = {1'b0, kcols_q};
    if (width_q == '0) wc = WW'(1);
    else if (int'(width_q) > MAX_WIDTH) wc = WW'(MAX_WIDTH);
    else wc = WW'(width_q);
    if (height_q == '0) hc = HW'(1);
    else if (int'(height_q) > MAX_HEIGHT) hc = HW'(MAX_HEIGHT);
    else hc = height_q;
    rdel     = (kr - 4'd1) >> 1;
    cdel     = (kc - 4'd1) >> 1;
    lat      = LAT_W'(rdel * wc) + LAT_W'(cdel);
    total_m1 = TOT_W'(wc * hc) - TOT_W'(1);
  end

  // pipeline advance
  logic en, accept, pos_item;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;
  assign pos_item   = (op_e'(opcode_i) == OP_PIXEL) || (op_e'(opcode_i) == OP_FLUSH);

  // position tracking
  logic [AW-1:0]    in_col_q, out_col_q;
  logic [HW-1:0]    out_row_q;
  logic [LAT_W-1:0] diff_q;
  logic [TOT_W-1:0] out_lin_q;
  logic             res_a, last_a;
  logic [MK-1:0]    rowok_a, colok_a;

  assign res_a  = diff_q >= lat;
  assign last_a = res_a && (out_lin_q >= total_m1);

  always_comb begin
    logic [HW:0] rr;
    logic [WW:0] cc;
    rr = (HW+1)'(out_row_q) + (HW+1)'(rdel);
    cc = (WW+1)'(out_col_q) + (WW+1)'(cdel);
    for (int k = 0; k < MK; k++) begin
      rowok_a[k] = (4'(k) < kr) && (rr >= (HW+1)'(k)) &&
                   ((rr - (HW+1)'(k)) < (HW+1)'(hc));
      colok_a[k] = (4'(k) < kc) && (cc >= (WW+1)'(k)) &&
                   ((cc - (WW+1)'(k)) < (WW+1)'(wc));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      diff_q    <= '0;
      out_lin_q <= '0;
    end else if (accept && pos_item) begin
      if (last_a) begin
        in_col_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        diff_q    <= '0;
        out_lin_q <= '0;
      end else begin
        if (WW'(in_col_q) + WW'(1) >= wc) in_col_q <= '0;
        else in_col_q <= in_col_q + AW'(1);
        if (res_a) begin
          out_lin_q <= out_lin_q + TOT_W'(1);
          if (WW'(out_col_q) + WW'(1) >= wc) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + HW'(1);
          end else begin
            out_col_q <= out_col_q + AW'(1);
          end
        end else begin
          diff_q <= diff_q + LAT_W'(1);
        end
      end
    end
  end

  // stage 1: line buffer read returns
  logic             s1_valid_q, s1_pos_q, s1_res_q, s1_last_q, s1_cwe_q;
  logic [MK-1:0]    s1_rowok_q, s1_colok_q;
  logic [4:0]       s1_cidx_q;
  logic [15:0]      s1_cval_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [AW-1:0]    s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_pos_q   <= 1'b0;
      s1_res_q   <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_cwe_q   <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s1_pos_q   <= in_valid_i && pos_item;
      s1_res_q   <= in_valid_i && pos_item && res_a;
      s1_last_q  <= last_a;
      s1_cwe_q   <= in_valid_i && (op_e'(opcode_i) == OP_COEFF) &&
                    (int'(coeff_index_i) < MK * MK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_rowok_q <= rowok_a;
      s1_colok_q <= colok_a;
      s1_cidx_q  <= coeff_index_i;
      s1_cval_q  <= coeff_value_i;
      s1_pix_q   <= (op_e'(opcode_i) == OP_PIXEL) ? {chan_c_i, chan_b_i, chan_a_i} : '0;
      s1_col_q   <= in_col_q;
    end
  end

  logic [LB_ROWS-1:0][PIX_W-1:0] lb_rdata, lb_wdata;
  logic [MK-1:0][PIX_W-1:0]      col_in;

  ic2d_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (LB_ROWS * PIX_W)
  ) u_linebuf (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (in_col_q),
    .rdata_o (lb_rdata),
    .we_i    (en && s1_valid_q && s1_pos_q),
    .waddr_i (s1_col_q),
    .wdata_i (lb_wdata)
  );

  always_comb begin
    col_in[0]   = s1_pix_q;
    lb_wdata[0] = s1_pix_q;
    for (int k = 1; k < MK; k++) begin
      col_in[k] = lb_rdata[k-1];
    end
    for (int r = 1; r < LB_ROWS; r++) begin
      lb_wdata[r] = lb_rdata[r-1];
    end
  end

  // stage 2: window valid in the cells
  logic          s2_valid_q, s2_res_q, s2_last_q, s2_cwe_q;
  logic [MK-1:0] s2_rowok_q, s2_colok_q;
  logic [4:0]    s2_cidx_q;
  logic [15:0]   s2_cval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_res_q   <= 1'b0;
      s2_last_q  <= 1'b0;
      s2_cwe_q   <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
      s2_res_q   <= s1_valid_q && s1_res_q;
      s2_last_q  <= s1_last_q;
      s2_cwe_q   <= s1_valid_q && s1_cwe_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_rowok_q <= s1_rowok_q;
      s2_colok_q <= s1_colok_q;
      s2_cidx_q  <= s1_cidx_q;
      s2_cval_q  <= s1_cval_q;
    end
  end

  // coefficient store, written in order with the item stream
  logic [MK*MK-1:0][CB-1:0] coeff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [23:0] cext;
    if (!rst_ni) begin
      coeff_q <= '0;
    end else if (en && s2_cwe_q) begin
      cext = 24'($signed(s2_cval_q));
      coeff_q[CIW'(s2_cidx_q)] <= cext[CB-1:0];
    end
  end

  logic [MK-1:0][MK-1:0][CB-1:0] coef_sel;
  logic [MK-1:0][MK-1:0]         mask_sel;

  always_comb begin
    int a;
    int b;
    for (int j = 0; j < MK; j++) begin
      for (int k = 0; k < MK; k++) begin
        a = int'(kr) - 1 - k;
        b = int'(kc) - 1 - j;
        mask_sel[j][k] = s2_rowok_q[k] && s2_colok_q[j];
        if (a >= 0 && b >= 0) begin
          coef_sel[j][k] = coeff_q[CIW'(a * MK + b)];
        end else begin
          coef_sel[j][k] = '0;
        end
      end
    end
  end

  // tap cells
  cell_ctrl_t                           cell_ctrl;
  logic [MK:0][MK-1:0][PIX_W-1:0]       chain;
  logic [MK-1:0][NUM_CH-1:0][SW-1:0]    col_sum;

  assign cell_ctrl.en    = en;
  assign cell_ctrl.shift = s1_valid_q && s1_pos_q;
  assign chain[0]        = col_in;

  for (genvar j = 0; j < MK; j++) begin : g_cell
    ic2d_cell #(
      .MK (MK),
      .CB (CB),
      .PW (PW),
      .SW (SW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .col_i  (chain[j]),
      .col_o  (chain[j+1]),
      .mask_i (mask_sel[j]),
      .coef_i (coef_sel[j]),
      .sum_o  (col_sum[j])
    );
  end

  // stages 3 to 5
  logic s3_res_q, s3_last_q, s4_res_q, s4_last_q, s5_res_q, s5_last_q;
  logic signed [ACC_W-1:0] sum_d [NUM_CH];
  logic signed [ACC_W-1:0] sum_q [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_res_q  <= 1'b0;
      s3_last_q <= 1'b0;
      s4_res_q  <= 1'b0;
      s4_last_q <= 1'b0;
      s5_res_q  <= 1'b0;
      s5_last_q <= 1'b0;
    end else if (en) begin
      s3_res_q  <= s2_valid_q && s2_res_q;
      s3_last_q <= s2_last_q;
      s4_res_q  <= s3_res_q;
      s4_last_q <= s3_last_q;
      s5_res_q  <= s4_res_q;
      s5_last_q <= s4_last_q;
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_d[ch] = '0;
      for (int j = 0; j < MK; j++) begin
        sum_d[ch] = sum_d[ch] + ACC_W'($signed(col_sum[j][ch]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sum_d;
    end
  end

  // truncate toward zero and clamp to 0..255
  logic [NUM_CH-1:0][CH_W-1:0] sat;

  always_comb begin
    logic signed [EXT_W-1:0] ext;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      ext = EXT_W'(sum_q[ch]);
      if (ext[EXT_W-1]) begin
        sat[ch] = '0;
      end else if (|ext[EXT_W-2:FRAC_BITS+CH_W]) begin
        sat[ch] = '1;
      end else begin
        sat[ch] = ext[FRAC_BITS +: CH_W];
      end
    end
  end

  logic [CH_W-1:0] res_a_q, res_b_q, res_c_q;
  logic            last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s5_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_a_q <= sat[0];
      res_b_q <= colour_q ? sat[1] : '0;
      res_c_q <= colour_q ? sat[2] : '0;
      last_q  <= s5_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign res_a_o      = res_a_q;
  assign res_b_o      = res_b_q;
  assign res_c_o      = res_c_q;
  assign frame_last_o = last_q;

endmodule

/* rtl/ic2d_checker.sv */
module ic2d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] res_a_o,
  input logic [7:0] res_b_o,
  input logic [7:0] res_c_o,
  input logic       frame_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(res_a_o) && $stable(res_b_o) && $stable(res_c_o) && $stable(frame_last_o))
    else $error("result changed while stalled");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input not ready while output is free");

  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input ready while output is stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

endmodule

bind image_2d_convolution ic2d_checker u_ic2d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .res_a_o      (res_a_o),
  .res_b_o      (res_b_o),
  .res_c_o      (res_c_o),
  .frame_last_o (frame_last_o)
);

/* tb/image_2d_convolution_checker.sv */
module image_2d_convolution_checker import ic2d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  coeff_index_i,
  input  logic [15:0] coeff_value_i,
  input  logic [7:0]  chan_a_i,
  input  logic [7:0]  chan_b_i,
  input  logic [7:0]  chan_c_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  res_a_i,
  input  logic [7:0]  res_b_i,
  input  logic [7:0]  res_c_i,
  input  logic        frame_last_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          result_cnt_o,
  output logic        frame_start_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KMAX      = MAX_KERNEL_DEF;
  localparam int WMAX      = MAX_WIDTH_DEF;
  localparam int ROWS_KEPT = KMAX + 1;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic       last;
  } conv_pix_t;

  conv_pix_t                    conv_pix_q[$];
  logic signed [15:0]           kernel_mem [KMAX*KMAX];
  logic [PIX_W-1:0]             row_mem [ROWS_KEPT*WMAX];
  int                           k_rows, k_cols, f_width, f_height;
  logic                         colour;
  int                           in_row, in_col, out_row, out_col;

  assign pending_o     = conv_pix_q.size();
  assign frame_start_o = (in_row == 0) && (in_col == 0) && (out_row == 0) && (out_col == 0);

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [7:0] to_byte(longint acc);
    longint v;
    v = acc / 4096;
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  task automatic advance_stream(logic [1:0] op, logic [4:0] idx, logic [15:0] val,
                                logic [PIX_W-1:0] pix);
    int kr, kc, w, h, ki, kj, slot;
    longint in_lin, out_lin, lag;
    longint acc [3];
    conv_pix_t res;
    kr = clip(k_rows, 1, KMAX);
    kc = clip(k_cols, 1, KMAX);
    w  = clip(f_width, 1, WMAX);
    h  = clip(f_height, 1, MAX_HEIGHT);
    if (op == OP_COEFF) begin
      if (idx < KMAX*KMAX) kernel_mem[idx] = val;
      return;
    end
    if (op != OP_PIXEL && op != OP_FLUSH) return;
    if (in_row < h && in_col < w)
      row_mem[(in_row % ROWS_KEPT) * WMAX + in_col] = (op == OP_PIXEL) ? pix : '0;
    in_lin  = longint'(in_row) * w + in_col;
    out_lin = longint'(out_row) * w + out_col;
    lag     = longint'((kr - 1) / 2) * w + (kc - 1) / 2;
    if (in_lin - out_lin >= lag) begin
      acc = '{0, 0, 0};
      for (int r = 0; r < kr; r++) begin
        ki = out_row + r - kr / 2;
        if (ki < 0 || ki >= h) continue;
        for (int c = 0; c < kc; c++) begin
          kj = out_col + c - kc / 2;
          if (kj < 0 || kj >= w) continue;
          slot = (ki % ROWS_KEPT) * WMAX + kj;
          for (int ch = 0; ch < NUM_CH; ch++)
            acc[ch] += longint'(row_mem[slot][CH_W*ch +: CH_W]) *
                       longint'(kernel_mem[r*KMAX + c]);
        end
      end
      res.a    = to_byte(acc[0]);
      res.b    = colour ? to_byte(acc[1]) : 8'd0;
      res.c    = colour ? to_byte(acc[2]) : 8'd0;
      res.last = (out_lin >= longint'(w) * h - 1);
      conv_pix_q.push_back(res);
      if (res.last) begin
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        return;
      end
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
  endtask

  task automatic note_fail(string what, conv_pix_t exp_pix, conv_pix_t got);
    if (fail_cnt_o < 10)
      $display("%0t mismatch %s: exp a=%0d b=%0d c=%0d last=%0b got a=%0d b=%0d c=%0d last=%0b",
               $realtime, what, exp_pix.a, exp_pix.b, exp_pix.c, exp_pix.last,
               got.a, got.b, got.c, got.last);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    conv_pix_t got;
    conv_pix_t exp_pix;
    if (!rst_ni) begin
      conv_pix_q.delete();
      foreach (kernel_mem[i]) kernel_mem[i] = '0;
      k_rows = 3; k_cols = 3; f_width = 640; f_height = 480; colour = 1'b1;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      fail_cnt_o = 0;
      result_cnt_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{res_a_i, res_b_i, res_c_i, frame_last_i};
        result_cnt_o++;
        if (conv_pix_q.size() == 0) begin
          note_fail("unexpected result", '0, got);
        end else begin
          exp_pix = conv_pix_q.pop_front();
          if (got.a !== exp_pix.a) note_fail("res_a", exp_pix, got);
          if (got.b !== exp_pix.b) note_fail("res_b", exp_pix, got);
          if (got.c !== exp_pix.c) note_fail("res_c", exp_pix, got);
          if (got.last !== exp_pix.last) note_fail("frame_last", exp_pix, got);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_KROWS:  k_rows   = cfg_data_i[2:0];
          CFG_KCOLS:  k_cols   = cfg_data_i[2:0];
          CFG_WIDTH:  f_width  = cfg_data_i[10:0];
          CFG_HEIGHT: f_height = cfg_data_i[12:0];
          CFG_COLOUR: colour   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        advance_stream(opcode_i, coeff_index_i, coeff_value_i,
                       {chan_c_i, chan_b_i, chan_a_i});
    end
  end
endmodule

/* tb/image_2d_convolution_tb.sv */
module image_2d_convolution_tb import ic2d_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         ITEM_GOAL = 1950;
  localparam int         MAX_CYCLES = 1500000;
  localparam int         DRAIN_CYCLES = 12;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid, in_ready;
  logic [1:0]  opcode;
  logic [4:0]  coeff_index;
  logic signed [15:0] coeff_value;
  logic [7:0]  chan_a, chan_b, chan_c;
  logic        out_valid, out_ready;
  logic [7:0]  res_a, res_b, res_c;
  logic        frame_last;
  int          fail_cnt, pending, result_cnt;
  logic        frame_start;
  int          cycle_cnt, item_cnt, cfg_cnt;
  bit          in_calm, out_calm, hold_req, hold_done;

  image_2d_convolution i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .coeff_index_i(coeff_index), .coeff_value_i(coeff_value),
    .chan_a_i(chan_a), .chan_b_i(chan_b), .chan_c_i(chan_c),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .res_a_o(res_a), .res_b_o(res_b), .res_c_o(res_c), .frame_last_o(frame_last)
  );

  image_2d_convolution_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .opcode_i(opcode), .coeff_index_i(coeff_index), .coeff_value_i(coeff_value),
    .chan_a_i(chan_a), .chan_b_i(chan_b), .chan_c_i(chan_c),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .res_a_i(res_a), .res_b_i(res_b), .res_c_i(res_c), .frame_last_i(frame_last),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .result_cnt_o(result_cnt),
    .frame_start_o(frame_start)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [7:0] pick_chan();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  // hold for long stretch once on request, always ready when calm, otherwise short and rare long stalls
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end else if (out_calm) begin
        out_ready = 1'b1;
      end else begin
        out_ready = (pick_gap(1'b0) == 0);
        if (!out_ready) repeat (pick_gap(1'b0)) @(negedge clk);
      end
    end
  end

  task automatic send(logic [1:0] op, logic [4:0] idx, logic [15:0] val,
                      logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op; coeff_index = idx; coeff_value = val;
    chan_a = a; chan_b = b; chan_c = c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op != OP_UNUSED && !(op == OP_COEFF && idx >= 25)) item_cnt++;
  endtask

  task automatic send_pixel();
    send(OP_PIXEL, 5'($urandom), 16'($urandom), pick_chan(), pick_chan(), pick_chan());
  endtask

  task automatic close_frame();
    while (!frame_start) begin
      if ($urandom_range(0, 3) == 0) send_pixel();
      else send(OP_FLUSH, 5'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom));
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [12:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic setup(int kr, int kc, int w, int h, bit col);
    write_reg(CFG_KROWS, 13'(kr));
    write_reg(CFG_KCOLS, 13'(kc));
    write_reg(CFG_WIDTH, 13'(w));
    write_reg(CFG_HEIGHT, 13'(h));
    write_reg(CFG_COLOUR, 13'(col));
    cfg_valid = 1'b0;
    cfg_cnt++;
  endtask

  task automatic load_kernel(bit wide);
    logic [15:0] v;
    for (int i = 0; i < 25; i++) begin
      if (wide) v = 16'($urandom);
      else v = 16'(int'($urandom_range(0, 3000)) - 1000);
      send(OP_COEFF, 5'(i), v, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_frame(int w, int h);
    int n, eff;
    int r;
    eff = ((w < 1) ? 1 : (w > 1024 ? 1024 : w)) * ((h < 1) ? 1 : (h > 4096 ? 4096 : h));
    n = 0;
    while (n < eff) begin
      r = $urandom_range(0, 99);
      if (r == 0) begin
        send(OP_UNUSED, 5'($urandom), 16'($urandom), pick_chan(), pick_chan(), pick_chan());
      end else if (r == 1) begin
        send(OP_COEFF, 5'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom));
      end else if (r == 2) begin
        send(OP_FLUSH, 5'($urandom), 16'($urandom), pick_chan(), pick_chan(), pick_chan());
        n++;
      end else begin
        send_pixel();
        n++;
      end
    end
    close_frame();
  endtask

  initial begin
    int kr, kc, w, h;
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; opcode = OP_PIXEL; coeff_index = '0; coeff_value = '0;
    chan_a = '0; chan_b = '0; chan_c = '0;
    in_calm = 1'b0; out_calm = 1'b0; hold_req = 1'b0; hold_done = 1'b0;
    cycle_cnt = 0; item_cnt = 0; cfg_cnt = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    setup(3, 3, 4, 3, 1'b1);
    send(OP_COEFF, 5'd6, 16'sd4096, 8'd0, 8'd0, 8'd0);
    send(OP_COEFF, 5'd0, 16'sd32767, 8'd0, 8'd0, 8'd0);
    send(OP_COEFF, 5'd24, -16'sd32768, 8'd0, 8'd0, 8'd0);
    send(OP_COEFF, 5'd25, 16'sd1234, 8'd0, 8'd0, 8'd0);
    send(OP_COEFF, 5'd31, -16'sd1, 8'd0, 8'd0, 8'd0);
    send(OP_UNUSED, 5'd0, 16'sd0, 8'd255, 8'd255, 8'd255);
    send(OP_PIXEL, 5'd0, 16'sd0, 8'd255, 8'd0, 8'd255);
    send(OP_PIXEL, 5'd0, 16'sd0, 8'd0, 8'd255, 8'd0);
    send(OP_FLUSH, 5'd0, 16'sd0, 8'd255, 8'd255, 8'd255);
    send(OP_PIXEL, 5'd0, 16'sd0, 8'd255, 8'd255, 8'd255);
    close_frame();
    drain();
    setup(5, 4, 3, 2, 1'b0);
    send(OP_COEFF, 5'd12, -16'sd4096, 8'd0, 8'd0, 8'd0);
    repeat (6) send_pixel();
    close_frame();
    drain();
    setup(0, 7, 0, 0, 1'b1);
    send(OP_PIXEL, 5'd0, 16'sd0, 8'd200, 8'd100, 8'd50);
    close_frame();
    drain();

    // fill the pipeline against a stalled receiver
    setup(1, 7, 2047, 1, 1'b1);
    load_kernel(1'b0);
    in_calm = 1'b1;
    hold_req = 1'b1;
    run_frame(2047, 1);
    in_calm = 1'b0;
    drain();
    setup(5, 1, 1, 6, 1'b0);
    load_kernel(1'b1);
    repeat (6) send_pixel();
    close_frame();
    drain();

    while (item_cnt < ITEM_GOAL) begin
      kr = $urandom_range(0, 7);
      kc = $urandom_range(0, 7);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
      h = $urandom_range(0, 7);
      setup(kr, kc, w, h, 1'($urandom));
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      load_kernel($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 2)) run_frame(w, h);
      drain();
    end

    out_calm = 1'b1;
    drain();
    $display("stimulus: %0d input transactions over %0d configurations, %0d results checked",
             item_cnt, cfg_cnt, result_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("failures: %0d, results still expected: %0d", fail_cnt, pending);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* image_2d_convolution.f */
rtl/ic2d_pkg.sv
rtl/ic2d_linebuf.sv
rtl/ic2d_cell.sv
rtl/image_2d_convolution.sv
rtl/ic2d_checker.sv
tb/image_2d_convolution_checker.sv
tb/image_2d_convolution_tb.sv
